/* rtl/phong_shading_assert.svh */
// ----------------------------------------------------------------------------
// Phong shading assertion macros
// Shared property forms for the shading unit's checkers.
// ----------------------------------------------------------------------------
`ifndef PHONG_SHADING_ASSERT_SVH
`define PHONG_SHADING_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define PHS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define PHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/phs_pkg.sv */
// ----------------------------------------------------------------------------
// phs_pkg
// Types, widths and fixed-point helpers of the Phong shading pipeline.
// ----------------------------------------------------------------------------
package phs_pkg;

  localparam int VEC_FRAC_BITS = 14;
  localparam int VCW   = 16;                  // vector component
  localparam int CHW   = 16;                  // one colour channel
  localparam int SHW   = 16;                  // shininess, Q8.8
  localparam int TW    = VEC_FRAC_BITS + 1;   // term in [0, 1]
  localparam int RW    = 31;                  // normalized reflection, signed
  localparam int M2W   = 2 * RW;              // squared length
  localparam int MAGW  = M2W / 2;             // length
  localparam int DOTW  = 48;                  // R.V, signed
  localparam int NUMW  = DOTW - 1;            // positive R.V
  localparam int ROOTW = VEC_FRAC_BITS;       // base and its roots
  localparam int RADW  = 2 * VEC_FRAC_BITS;   // radicand of a fractional root

  localparam logic [TW-1:0] TERM_ONE = TW'(1) << VEC_FRAC_BITS;

  typedef logic signed [VCW-1:0] vcomp_t;
  typedef logic [3*CHW-1:0] rgb_t;

  typedef struct packed {
    vcomp_t nx, ny, nz;
    vcomp_t lx, ly, lz;
    vcomp_t vx, vy, vz;
    rgb_t kd;
    rgb_t ks;
    logic [SHW-1:0] shin;
  } item_t;

  typedef struct packed {
    logic [TW-1:0]  dterm;
    logic [SHW-1:0] shin;
    rgb_t kd;
    rgb_t ks;
  } side_t;

  typedef struct packed {
    logic signed [DOTW-1:0] dotrv;
    side_t side;
  } geo_t;

  // done marks a term already settled by a special case; acc then holds it.
  typedef struct packed {
    logic done;
    logic [TW-1:0] acc;
    side_t side;
  } pow_t;

  function automatic logic [TW-1:0] fmul(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [2*TW-1:0] p;
    p = a * b;
    return p[VEC_FRAC_BITS +: TW];
  endfunction

endpackage

/* rtl/phong_shading.sv */
// ----------------------------------------------------------------------------
// phong_shading
// Fixed-point Phong shading: one RGB sample per request, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel   dir  width  contents
//  in_*      in   256    normal, light, view (Q2.14), Kd, Ks (3 x Q4.12), shininess
//  out_*     out  48     shaded red, green, blue (Q4.12, saturated)
//
//  Throughput: one request per clock with no stall at the output.
//  Pipeline: front end, |R| root, division and power (dominated by eight
//    14-stage fractional roots), colour mix.
//  Reset: synchronous, active low; clears every valid bit, data is not reset.
//  Stall: all stages hold while a result waits; the first stage still takes a
//    request when it is empty, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module phong_shading (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // normal_x, normal_y, normal_z, light_x, light_y, light_z,
  // view_x, view_y, view_z, diffuse_rgb, specular_rgb, shininess
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // shade_r, shade_g, shade_b
  output logic [47:0]  out_tdata
);
  import phs_pkg::*;

  localparam int PW  = TW + CHW;        // term times channel
  localparam int SUW = PW + 1;
  localparam int CRW = SUW - VEC_FRAC_BITS;

  logic  pipe_en;
  item_t in_item;

  // front end
  logic           fr_vld;
  logic [M2W-1:0] fr_mag2;
  geo_t           fr_geo;

  // |R| root
  logic            mg_vld;
  logic [MAGW-1:0] mg_mag;
  geo_t            mg_geo;

  // power
  logic pw_vld;
  pow_t pw_st;

  // colour mix
  logic          m1_vld_r;
  logic [PW-1:0] pd_r [3];
  logic [PW-1:0] ps_r [3];
  logic [PW-1:0] pd_nxt [3];
  logic [PW-1:0] ps_nxt [3];
  logic          out_vld_r;
  logic [47:0]   out_data_r, out_data_nxt;
  logic [SUW-1:0] csum [3];
  logic [CRW-1:0] cshift [3];

  // advance everything whenever the output register is free or being drained
  assign pipe_en = !out_vld_r || out_tready;

  // unpack request: first field in the lowest bits
  always_comb begin
    in_item.nx   = in_tdata[15:0];
    in_item.ny   = in_tdata[31:16];
    in_item.nz   = in_tdata[47:32];
    in_item.lx   = in_tdata[63:48];
    in_item.ly   = in_tdata[79:64];
    in_item.lz   = in_tdata[95:80];
    in_item.vx   = in_tdata[111:96];
    in_item.vy   = in_tdata[127:112];
    in_item.vz   = in_tdata[143:128];
    in_item.kd   = in_tdata[191:144];
    in_item.ks   = in_tdata[239:192];
    in_item.shin = in_tdata[255:240];
  end

  phs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .out_valid (fr_vld),
    .out_mag2  (fr_mag2),
    .out_geo   (fr_geo)
  );

  // floor sqrt of |R|^2, R.V and colours ride alongside
  phs_isqrt #(
    .W  (M2W),
    .PW ($bits(geo_t))
  ) u_mag (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (fr_vld),
    .in_rad    (fr_mag2),
    .in_pay    (fr_geo),
    .out_valid (mg_vld),
    .out_root  (mg_mag),
    .out_pay   (mg_geo)
  );

  phs_pow u_pow (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (mg_vld),
    .in_mag    (mg_mag),
    .in_geo    (mg_geo),
    .out_valid (pw_vld),
    .out_st    (pw_st)
  );

  // channel 0 is red (bits 47:32 of the colour words)
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pd_nxt[c] = pw_st.side.dterm * pw_st.side.kd[CHW*(2-c) +: CHW];
      ps_nxt[c] = pw_st.acc * pw_st.side.ks[CHW*(2-c) +: CHW];
    end
  end

  // add, drop fraction bits, saturate at full scale
  always_comb begin
    out_data_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      csum[c]   = SUW'(pd_r[c]) + SUW'(ps_r[c]);
      cshift[c] = CRW'(csum[c] >> VEC_FRAC_BITS);
      if (cshift[c][CRW-1:CHW] != '0) begin
        out_data_nxt[CHW*c +: CHW] = '1;
      end else begin
        out_data_nxt[CHW*c +: CHW] = cshift[c][CHW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (pipe_en) begin
      m1_vld_r  <= pw_vld;
      out_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int c = 0; c < 3; c++) begin
        pd_r[c] <= pd_nxt[c];
        ps_r[c] <= ps_nxt[c];
      end
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/phs_isqrt.sv */
// ----------------------------------------------------------------------------
// phs_isqrt
// Pipelined floor square root, one root bit per stage, with a side payload.
// ----------------------------------------------------------------------------
module phs_isqrt #(
  parameter int W  = 28,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  in_rad,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [W/2-1:0] out_root,
  output logic [PW-1:0] out_pay
);
  localparam int N = W / 2;

  logic [N-1:0]  vld_r;
  logic [W-1:0]  rem_r   [N];
  logic [N-1:0]  q_r     [N];
  logic [PW-1:0] pay_r   [N];
  logic [W-1:0]  rem_nxt [N];
  logic [N-1:0]  q_nxt   [N];
  logic [PW-1:0] pay_nxt [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int B = N - 1 - j;
    logic [W-1:0] rem_in;
    logic [N-1:0] q_in;
    logic [W+1:0] trial;
    logic         take;

    if (j == 0) begin : g_head
      assign rem_in     = in_rad;
      assign q_in       = '0;
      assign pay_nxt[j] = in_pay;
    end else begin : g_body
      assign rem_in     = rem_r[j-1];
      assign q_in       = q_r[j-1];
      assign pay_nxt[j] = pay_r[j-1];
    end

    // remainder holds x - q^2; try setting root bit B
    assign trial      = ((W+2)'(q_in) << (B + 1)) + ((W+2)'(1) << (2 * B));
    assign take       = {2'b00, rem_in} >= trial;
    assign rem_nxt[j] = take ? rem_in - trial[W-1:0] : rem_in;
    assign q_nxt[j]   = take ? (q_in | (N'(1) << B)) : q_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < N; j++) begin
        rem_r[j] <= rem_nxt[j];
        q_r[j]   <= q_nxt[j];
        pay_r[j] <= pay_nxt[j];
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_root  = q_r[N-1];
  assign out_pay   = pay_r[N-1];

endmodule

/* rtl/phs_front.sv */
// ----------------------------------------------------------------------------
// phs_front
// Dot products, reflection vector, range normalization, |R|^2 and R.V.
// ----------------------------------------------------------------------------
module phs_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  phs_pkg::item_t        in_item,
  output logic                  out_valid,
  output logic [phs_pkg::M2W-1:0] out_mag2,
  output phs_pkg::geo_t         out_geo
);
  import phs_pkg::*;

  localparam int ST  = 7;
  localparam int SW  = 34;   // N.L sum
  localparam int SFW = 20;   // floor(N.L / one)
  localparam int AW  = 36;   // sf * n
  localparam int R4W = 37;   // raw reflection
  localparam int PVW = RW + VCW;
  localparam logic signed [SW-1:0] S_ONE = SW'(1) <<< (2 * VEC_FRAC_BITS);

  logic [ST-1:0] vld_r;
  logic          ce0;

  item_t                   it1_r, it2_r, it3_r, it4_r, it5_r;
  logic signed [31:0]      p1_r [3];
  logic signed [31:0]      p1_nxt [3];
  logic [TW-1:0]           dterm2_r, dterm3_r, dterm4_r, dterm5_r, dterm2_nxt;
  logic signed [SFW-1:0]   sf2_r, sf2_nxt;
  logic signed [SW-1:0]    s2;
  logic signed [AW-1:0]    a3_r [3];
  logic signed [AW-1:0]    a3_nxt [3];
  logic signed [R4W-1:0]   r4_r [3];
  logic signed [R4W-1:0]   r4_nxt [3];
  logic signed [RW-1:0]    r5_r [3];
  logic signed [RW-1:0]    r5_nxt [3];
  logic [R4W-1:0]          mag5 [3];
  logic [R4W-1:0]          orm5;
  logic [2:0]              sh5;
  logic [RW-2:0]           shm5 [3];
  side_t                   side6_r;
  logic [M2W-1:0]          sq6_r [3];
  logic [M2W-1:0]          sq6_nxt [3];
  logic signed [M2W-1:0]   sqs6 [3];
  logic signed [PVW-1:0]   rv6_r [3];
  logic signed [PVW-1:0]   rv6_nxt [3];
  logic [M2W-1:0]          mag2_r;
  geo_t                    geo_r;
  vcomp_t                  n2 [3], l3 [3], v5 [3];

  assign ce0      = en || !vld_r[0];
  assign in_ready = ce0;

  // S1: N.L partial products
  always_comb begin
    p1_nxt[0] = in_item.nx * in_item.lx;
    p1_nxt[1] = in_item.ny * in_item.ly;
    p1_nxt[2] = in_item.nz * in_item.lz;
  end

  // S2: diffuse term and floored N.L
  always_comb begin
    s2 = SW'(p1_r[0]) + SW'(p1_r[1]) + SW'(p1_r[2]);
    if (s2 <= 0) begin
      dterm2_nxt = '0;
    end else if (s2 >= S_ONE) begin
      dterm2_nxt = TERM_ONE;
    end else begin
      dterm2_nxt = TW'(s2 >>> VEC_FRAC_BITS);
    end
    sf2_nxt = SFW'(s2 >>> VEC_FRAC_BITS);
  end

  // S3: sf * N
  always_comb begin
    n2[0] = it2_r.nx;
    n2[1] = it2_r.ny;
    n2[2] = it2_r.nz;
    for (int i = 0; i < 3; i++) begin
      a3_nxt[i] = sf2_r * n2[i];
    end
  end

  // S4: R = 2 sf N - L one
  always_comb begin
    l3[0] = it3_r.lx;
    l3[1] = it3_r.ly;
    l3[2] = it3_r.lz;
    for (int i = 0; i < 3; i++) begin
      r4_nxt[i] = (R4W'(a3_r[i]) <<< 1) - (R4W'(l3[i]) <<< VEC_FRAC_BITS);
    end
  end

  // S5: shift magnitudes down until all fit below 2^30, keep signs
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag5[i] = r4_r[i][R4W-1] ? R4W'(-r4_r[i]) : R4W'(r4_r[i]);
    end
    orm5 = mag5[0] | mag5[1] | mag5[2];
    sh5  = '0;
    for (int b = RW - 1; b < R4W; b++) begin
      if (orm5[b]) begin
        sh5 = 3'(b - (RW - 2));
      end
    end
    for (int i = 0; i < 3; i++) begin
      shm5[i]   = (RW-1)'(mag5[i] >> sh5);
      r5_nxt[i] = r4_r[i][R4W-1] ? -$signed({1'b0, shm5[i]}) : $signed({1'b0, shm5[i]});
    end
  end

  // S6: squares and R.V partial products
  always_comb begin
    v5[0] = it5_r.vx;
    v5[1] = it5_r.vy;
    v5[2] = it5_r.vz;
    for (int i = 0; i < 3; i++) begin
      sqs6[i]    = r5_r[i] * r5_r[i];
      sq6_nxt[i] = M2W'(sqs6[i]);
      rv6_nxt[i] = r5_r[i] * v5[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ce0) begin
        vld_r[0] <= in_valid;
      end
      if (en) begin
        vld_r[ST-1:1] <= vld_r[ST-2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce0) begin
      it1_r <= in_item;
      for (int i = 0; i < 3; i++) p1_r[i] <= p1_nxt[i];
    end
    if (en) begin
      it2_r    <= it1_r;
      dterm2_r <= dterm2_nxt;
      sf2_r    <= sf2_nxt;
      it3_r    <= it2_r;
      dterm3_r <= dterm2_r;
      it4_r    <= it3_r;
      dterm4_r <= dterm3_r;
      it5_r    <= it4_r;
      dterm5_r <= dterm4_r;
      side6_r  <= '{dterm: dterm5_r, shin: it5_r.shin, kd: it5_r.kd, ks: it5_r.ks};
      for (int i = 0; i < 3; i++) begin
        a3_r[i]  <= a3_nxt[i];
        r4_r[i]  <= r4_nxt[i];
        r5_r[i]  <= r5_nxt[i];
        sq6_r[i] <= sq6_nxt[i];
        rv6_r[i] <= rv6_nxt[i];
      end
      // S7: sums
      mag2_r      <= sq6_r[0] + sq6_r[1] + sq6_r[2];
      geo_r.dotrv <= DOTW'(rv6_r[0]) + DOTW'(rv6_r[1]) + DOTW'(rv6_r[2]);
      geo_r.side  <= side6_r;
    end
  end

  assign out_valid = vld_r[ST-1];
  assign out_mag2  = mag2_r;
  assign out_geo   = geo_r;

endmodule

/* rtl/phs_pow.sv */
// ----------------------------------------------------------------------------
// phs_pow
// Specular base by restoring division, then base^shininess: integer bits by
// square-and-multiply, fraction bits by successive square roots.
// ----------------------------------------------------------------------------
module phs_pow (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [phs_pkg::MAGW-1:0] in_mag,
  input  phs_pkg::geo_t           in_geo,
  output logic                    out_valid,
  output phs_pkg::pow_t           out_st
);
  import phs_pkg::*;

  localparam int DIVN = ROOTW;
  localparam int IPN  = SHW - 8;
  localparam int FPN  = 8;

  // classify
  logic            q0_vld_r;
  pow_t            q0_st_r, q0_st_nxt;
  logic [NUMW-1:0] q0_num_r;
  logic [MAGW-1:0] q0_den_r;

  always_comb begin
    q0_st_nxt.side = in_geo.side;
    q0_st_nxt.done = 1'b1;
    q0_st_nxt.acc  = '0;
    if (in_geo.side.shin == '0) begin
      q0_st_nxt.acc = TERM_ONE;
    end else if (in_mag == '0 || in_geo.dotrv <= 0) begin
      q0_st_nxt.acc = '0;
    end else if (in_geo.dotrv[NUMW-1:0] >= (NUMW'(in_mag) << VEC_FRAC_BITS)) begin
      q0_st_nxt.acc = TERM_ONE;
    end else begin
      q0_st_nxt.done = 1'b0;
    end
  end

  // division, one quotient bit per stage
  logic [DIVN-1:0]  dvld_r;
  logic [NUMW-1:0]  rem_r [DIVN];
  logic [ROOTW-1:0] quo_r [DIVN];
  logic [MAGW-1:0]  den_r [DIVN];
  pow_t             dst_r [DIVN];
  logic [NUMW-1:0]  rem_nxt [DIVN];
  logic [ROOTW-1:0] quo_nxt [DIVN];
  logic [MAGW-1:0]  den_nxt [DIVN];
  pow_t             dst_nxt [DIVN];

  for (genvar j = 0; j < DIVN; j++) begin : g_div
    localparam int B = DIVN - 1 - j;
    logic [NUMW-1:0]  rem_in;
    logic [ROOTW-1:0] quo_in;
    logic [NUMW-1:0]  trial;
    logic             take;

    if (j == 0) begin : g_head
      assign rem_in     = q0_num_r;
      assign quo_in     = '0;
      assign den_nxt[j] = q0_den_r;
      assign dst_nxt[j] = q0_st_r;
    end else begin : g_body
      assign rem_in     = rem_r[j-1];
      assign quo_in     = quo_r[j-1];
      assign den_nxt[j] = den_r[j-1];
      assign dst_nxt[j] = dst_r[j-1];
    end

    assign trial      = NUMW'(den_nxt[j]) << B;
    assign take       = rem_in >= trial;
    assign rem_nxt[j] = take ? rem_in - trial : rem_in;
    assign quo_nxt[j] = take ? (quo_in | (ROOTW'(1) << B)) : quo_in;
  end

  // setup: zero base gives zero, otherwise start from one
  logic             su_vld_r;
  pow_t             su_st_r, su_st_nxt;
  logic [TW-1:0]    su_sq_r;
  logic [ROOTW-1:0] su_root_r;

  always_comb begin
    su_st_nxt = dst_r[DIVN-1];
    if (!su_st_nxt.done) begin
      if (quo_r[DIVN-1] == '0) begin
        su_st_nxt.done = 1'b1;
        su_st_nxt.acc  = '0;
      end else begin
        su_st_nxt.acc = TERM_ONE;
      end
    end
  end

  // integer exponent bits
  logic [IPN-1:0]   ivld_r;
  pow_t             ist_r [IPN];
  logic [TW-1:0]    isq_r [IPN];
  logic [ROOTW-1:0] iroot_r [IPN];
  pow_t             ist_nxt [IPN];
  logic [TW-1:0]    isq_nxt [IPN];
  logic [ROOTW-1:0] iroot_nxt [IPN];

  for (genvar j = 0; j < IPN; j++) begin : g_int
    pow_t          st_in;
    logic [TW-1:0] sq_in;

    if (j == 0) begin : g_head
      assign st_in        = su_st_r;
      assign sq_in        = su_sq_r;
      assign iroot_nxt[j] = su_root_r;
    end else begin : g_body
      assign st_in        = ist_r[j-1];
      assign sq_in        = isq_r[j-1];
      assign iroot_nxt[j] = iroot_r[j-1];
    end

    always_comb begin
      ist_nxt[j] = st_in;
      if (!st_in.done && st_in.side.shin[8+j]) begin
        ist_nxt[j].acc = fmul(st_in.acc, sq_in);
      end
      isq_nxt[j] = fmul(sq_in, sq_in);
    end
  end

  // fraction exponent bits: root, then multiply in
  logic [FPN-1:0]   fvld_r;
  pow_t             fst_r [FPN];
  logic [ROOTW-1:0] froot_r [FPN];
  logic             qv [FPN];
  logic [ROOTW-1:0] qroot [FPN];
  pow_t             qst [FPN];
  pow_t             fst_nxt [FPN];

  for (genvar i = 0; i < FPN; i++) begin : g_frac
    logic             v_in;
    logic [ROOTW-1:0] root_in;
    pow_t             st_in;

    if (i == 0) begin : g_head
      assign v_in    = ivld_r[IPN-1];
      assign root_in = iroot_r[IPN-1];
      assign st_in   = ist_r[IPN-1];
    end else begin : g_body
      assign v_in    = fvld_r[i-1];
      assign root_in = froot_r[i-1];
      assign st_in   = fst_r[i-1];
    end

    phs_isqrt #(
      .W  (RADW),
      .PW ($bits(pow_t))
    ) u_root (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (v_in),
      .in_rad    (RADW'(root_in) << VEC_FRAC_BITS),
      .in_pay    (st_in),
      .out_valid (qv[i]),
      .out_root  (qroot[i]),
      .out_pay   (qst[i])
    );

    always_comb begin
      fst_nxt[i] = qst[i];
      if (!qst[i].done && qst[i].side.shin[FPN-1-i]) begin
        fst_nxt[i].acc = fmul(qst[i].acc, TW'(qroot[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q0_vld_r <= 1'b0;
      dvld_r   <= '0;
      su_vld_r <= 1'b0;
      ivld_r   <= '0;
      fvld_r   <= '0;
    end else if (en) begin
      q0_vld_r <= in_valid;
      dvld_r   <= {dvld_r[DIVN-2:0], q0_vld_r};
      su_vld_r <= dvld_r[DIVN-1];
      ivld_r   <= {ivld_r[IPN-2:0], su_vld_r};
      for (int i = 0; i < FPN; i++) fvld_r[i] <= qv[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q0_st_r   <= q0_st_nxt;
      q0_num_r  <= in_geo.dotrv[NUMW-1:0];
      q0_den_r  <= in_mag;
      for (int j = 0; j < DIVN; j++) begin
        rem_r[j] <= rem_nxt[j];
        quo_r[j] <= quo_nxt[j];
        den_r[j] <= den_nxt[j];
        dst_r[j] <= dst_nxt[j];
      end
      su_st_r   <= su_st_nxt;
      su_sq_r   <= TW'(quo_r[DIVN-1]);
      su_root_r <= quo_r[DIVN-1];
      for (int j = 0; j < IPN; j++) begin
        ist_r[j]   <= ist_nxt[j];
        isq_r[j]   <= isq_nxt[j];
        iroot_r[j] <= iroot_nxt[j];
      end
      for (int i = 0; i < FPN; i++) begin
        fst_r[i]   <= fst_nxt[i];
        froot_r[i] <= qroot[i];
      end
    end
  end

  assign out_valid = fvld_r[FPN-1];
  assign out_st    = fst_r[FPN-1];

endmodule

/* rtl/phs_checker.sv */
// ----------------------------------------------------------------------------
// phs_checker
// Port-level checks of the Phong shading unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "phong_shading_assert.svh"

module phs_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [47:0]  out_tdata
);

  // a waiting result must hold still
  `PHS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // with the output register empty the pipeline must be open
  `PHS_ASSERT_IMPLY(a_open_when_empty, clk, rst_n, !out_tvalid, in_tready, "input blocked with empty output")

  // a drained result frees the whole pipeline, input included
  `PHS_ASSERT_IMPLY(a_open_on_drain, clk, rst_n, out_tvalid && out_tready, in_tready, "input blocked while output drains")

  // a stalled request stays blocked only while a result waits
  `PHS_ASSERT_IMPLY(a_block_cause, clk, rst_n, in_tvalid && !in_tready, out_tvalid && !out_tready, "input blocked without output stall")

endmodule

bind phong_shading phs_checker u_phs_checker (.*);
